>>> rtl/core/config_block_scan_macros.svh
// Assertion macros for the configuration block scanner.
`ifndef CONFIG_BLOCK_SCAN_MACROS_SVH
`define CONFIG_BLOCK_SCAN_MACROS_SVH

// Checked on every rising edge of clk_i, suspended while reset is asserted.
`define CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, including while reset is asserted.
`define CBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/cbs_pkg.sv
// Shared types and constants of the configuration block scanner.
`default_nettype none

package cbs_pkg;

  localparam int unsigned CountW  = 23;
  localparam int unsigned ByteW   = 25;
  localparam int unsigned SkipW   = 14;
  localparam int unsigned WordW   = 32;

  localparam logic [CountW-1:0] RegionWordsReset = 23'd262144;
  localparam logic [CountW-1:0] WordsMax         = 23'd4194304;
  localparam logic [15:0]       SizeErased       = 16'hFFFF;

  typedef enum logic [1:0] {
    StatusEnd       = 2'd0,
    StatusCorrupt   = 2'd1,
    StatusExhausted = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> rtl/core/config_block_scan.sv
// Configuration block scanner: walks flash configuration records one word at a time.
// Result path: the word that ends the walk waits in the input register, then the result
// register loads and the result is valid on the output.
// Throughput: one word per cycle; the input side stalls only while a finished result
// waits to be taken and the word in the input register would produce the next one.
// Reset: rst_ni clears the walk state, the valid flags and sets region_words to 262144.
`default_nettype none

`include "config_block_scan_macros.svh"

module config_block_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: region length in 32-bit words.
  input  logic        cfg_we_i,
  input  logic [22:0] cfg_wdata_i,
  // Region word stream.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] word_i,
  // Scan summary.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [22:0] live_count_o,
  output logic [22:0] record_count_o,
  output logic [24:0] live_bytes_o,
  output logic [24:0] recyclable_bytes_o,
  output logic [24:0] wasted_bytes_o,
  output logic [24:0] free_offset_o,
  output logic [24:0] free_bytes_o
);

  // Configuration register.
  logic [cbs_pkg::CountW-1:0] region_words_q;

  // Input register: one word waiting to be walked.
  logic                      s1_valid_q;
  logic [cbs_pkg::WordW-1:0] word_q;
  logic                      s1_fire;

  // Walk state and its next values.
  logic [cbs_pkg::CountW-1:0] word_index_q, word_index_d;
  logic [cbs_pkg::SkipW-1:0]  skip_left_q, skip_left_d;
  logic [cbs_pkg::ByteW-1:0]  stop_offset_q, stop_offset_d;
  logic [cbs_pkg::CountW-1:0] live_total_q, live_total_d;
  logic [cbs_pkg::CountW-1:0] record_total_q, record_total_d;
  logic [cbs_pkg::ByteW-1:0]  live_sum_q, live_sum_d;
  logic [cbs_pkg::ByteW-1:0]  recycle_sum_q, recycle_sum_d;
  logic [cbs_pkg::ByteW-1:0]  waste_sum_q, waste_sum_d;
  logic                       finished_q, finished_d;

  // Result register.
  logic                       out_valid_q;
  cbs_pkg::status_e           status_q;
  logic [cbs_pkg::CountW-1:0] live_count_q, record_count_q;
  logic [cbs_pkg::ByteW-1:0]  live_bytes_q, recyclable_bytes_q, wasted_bytes_q;
  logic [cbs_pkg::ByteW-1:0]  free_offset_q, free_bytes_q;

  // Step outputs.
  logic                       has_result;
  cbs_pkg::status_e           res_status;
  logic [cbs_pkg::CountW-1:0] res_live_count, res_record_count;
  logic [cbs_pkg::ByteW-1:0]  res_live_bytes, res_recyclable_bytes, res_wasted_bytes;
  logic [cbs_pkg::ByteW-1:0]  res_free_offset, res_free_bytes;

  // Effective region length: zero counts as one word, and the length is clamped
  // to the largest supported region.
  logic [cbs_pkg::CountW-1:0] span_words;
  logic [cbs_pkg::ByteW-1:0]  region_bytes;

  always_comb begin
    if (region_words_q == '0) begin
      span_words = {{(cbs_pkg::CountW-1){1'b0}}, 1'b1};
    end else if (region_words_q > cbs_pkg::WordsMax) begin
      span_words = cbs_pkg::WordsMax;
    end else begin
      span_words = region_words_q;
    end
  end

  assign region_bytes = {span_words, 2'b00};

  // A word in the input register moves on unless it would produce a result while
  // the result register still holds one that has not been taken.
  assign s1_fire    = s1_valid_q && !(has_result && out_valid_q && !out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // One walk step for the word in the input register.
  always_comb begin
    logic [15:0]                size;
    logic [7:0]                 name_len;
    logic [7:0]                 padded_name;
    logic [8:0]                 name_sum;
    logic [16:0]                padded;
    logic [14:0]                body_words;
    logic [7:0]                 waste;
    logic [cbs_pkg::CountW-1:0] index_inc;
    logic [cbs_pkg::CountW-1:0] end_words;

    size        = word_q[15:0];
    name_len    = word_q[31:24];
    name_sum    = {1'b0, name_len} + 9'd3;
    padded_name = name_sum[7:0] & 8'hFC;
    padded      = ({1'b0, size} + 17'd3) & 17'h1FFFC;
    body_words  = padded[16:2] - 15'd1;
    waste       = padded[7:0] - size[7:0] + padded_name - name_len;
    index_inc   = word_index_q + {{(cbs_pkg::CountW-1){1'b0}}, 1'b1};

    word_index_d   = word_index_q;
    skip_left_d    = skip_left_q;
    stop_offset_d  = stop_offset_q;
    live_total_d   = live_total_q;
    record_total_d = record_total_q;
    live_sum_d     = live_sum_q;
    recycle_sum_d  = recycle_sum_q;
    waste_sum_d    = waste_sum_q;
    finished_d     = finished_q;
    has_result     = 1'b0;
    res_status     = cbs_pkg::StatusEnd;
    end_words      = '0;

    if (!finished_q) begin
      if (skip_left_q != '0) begin
        skip_left_d = skip_left_q - {{(cbs_pkg::SkipW-1){1'b0}}, 1'b1};
      end else if (size == 16'd0 || size == cbs_pkg::SizeErased) begin
        // Erased marker or corrupt zero-size header: the walk stops here.
        finished_d    = 1'b1;
        stop_offset_d = {word_index_q, 2'b00};
        has_result    = 1'b1;
        res_status    = (size == 16'd0) ? cbs_pkg::StatusCorrupt : cbs_pkg::StatusEnd;
      end else begin
        if (word_q[16]) begin
          live_total_d = live_total_q + {{(cbs_pkg::CountW-1){1'b0}}, 1'b1};
          live_sum_d   = live_sum_q + {{(cbs_pkg::ByteW-17){1'b0}}, padded};
          waste_sum_d  = waste_sum_q + {{(cbs_pkg::ByteW-8){1'b0}}, waste};
        end else begin
          recycle_sum_d = recycle_sum_q + {{(cbs_pkg::ByteW-17){1'b0}}, padded};
        end
        record_total_d = record_total_q + {{(cbs_pkg::CountW-1){1'b0}}, 1'b1};
        skip_left_d    = body_words[cbs_pkg::SkipW-1:0];
      end
    end

    word_index_d = index_inc;

    // End of region: a walk still running reports exhaustion, with the offset
    // pointing past the last record, even where that record overruns the region.
    if (index_inc >= span_words && !finished_d) begin
      end_words     = index_inc + {{(cbs_pkg::CountW-cbs_pkg::SkipW){1'b0}}, skip_left_d};
      stop_offset_d = {end_words, 2'b00};
      has_result    = 1'b1;
      res_status    = cbs_pkg::StatusExhausted;
    end

    res_live_count       = live_total_d;
    res_record_count     = record_total_d;
    res_live_bytes       = live_sum_d;
    res_recyclable_bytes = recycle_sum_d;
    res_wasted_bytes     = waste_sum_d;
    res_free_offset      = stop_offset_d;
    res_free_bytes       = (region_bytes > stop_offset_d) ? (region_bytes - stop_offset_d) : '0;

    // Rearm for the next region once the last region word has been taken.
    if (index_inc >= span_words) begin
      word_index_d   = '0;
      skip_left_d    = '0;
      stop_offset_d  = '0;
      live_total_d   = '0;
      record_total_d = '0;
      live_sum_d     = '0;
      recycle_sum_d  = '0;
      waste_sum_d    = '0;
      finished_d     = 1'b0;
    end
  end

  // Control and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_words_q <= cbs_pkg::RegionWordsReset;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      word_index_q   <= '0;
      skip_left_q    <= '0;
      stop_offset_q  <= '0;
      live_total_q   <= '0;
      record_total_q <= '0;
      live_sum_q     <= '0;
      recycle_sum_q  <= '0;
      waste_sum_q    <= '0;
      finished_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        region_words_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        word_index_q   <= word_index_d;
        skip_left_q    <= skip_left_d;
        stop_offset_q  <= stop_offset_d;
        live_total_q   <= live_total_d;
        record_total_q <= record_total_d;
        live_sum_q     <= live_sum_d;
        recycle_sum_q  <= recycle_sum_d;
        waste_sum_q    <= waste_sum_d;
        finished_q     <= finished_d;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_i;
    end
    if (s1_fire && has_result) begin
      status_q           <= res_status;
      live_count_q       <= res_live_count;
      record_count_q     <= res_record_count;
      live_bytes_q       <= res_live_bytes;
      recyclable_bytes_q <= res_recyclable_bytes;
      wasted_bytes_q     <= res_wasted_bytes;
      free_offset_q      <= res_free_offset;
      free_bytes_q       <= res_free_bytes;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign live_count_o       = live_count_q;
  assign record_count_o     = record_count_q;
  assign live_bytes_o       = live_bytes_q;
  assign recyclable_bytes_o = recyclable_bytes_q;
  assign wasted_bytes_o     = wasted_bytes_q;
  assign free_offset_o      = free_offset_q;
  assign free_bytes_o       = free_bytes_q;

  // A stopped walk never has record body words left to skip.
  `CBS_ASSERT(a_finished_no_skip, finished_q |-> (skip_left_q == '0), "stopped walk still skipping")
  // Live records are a subset of all records walked.
  `CBS_ASSERT(a_live_le_records, live_total_q <= record_total_q, "live count exceeds records")
  // The input side only stalls behind a result that has not been taken.
  `CBS_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
              "input stalled without a pending result")
  // No result is offered in the cycle after reset has been seen.
  `CBS_ASSERT_ALWAYS(a_reset_clears_out, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

`default_nettype wire
